// ===== rtl/core/lsqf_pkg.sv =====
// ----------------------------------------------------------------------------
// lsqf_pkg: shared types and codes of the load/store queue
// Command and status codes plus the token passed along the store-cell chain.
// ----------------------------------------------------------------------------
package lsqf_pkg;

	typedef enum logic [2:0] {
		CMD_ALLOC_LOAD   = 3'd0,
		CMD_ALLOC_STORE  = 3'd1,
		CMD_STORE_READY  = 3'd2,
		CMD_EXEC_LOAD    = 3'd3,
		CMD_RETIRE_LOAD  = 3'd4,
		CMD_RETIRE_STORE = 3'd5,
		CMD_CLEAR        = 3'd6,
		CMD_BAD          = 3'd7
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_FULL  = 3'd1,
		ST_WAIT  = 3'd2,
		ST_FWD   = 3'd3,
		ST_MEM   = 3'd4,
		ST_ORDER = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		WS_IDLE = 2'd0,
		WS_WALK = 2'd1,
		WS_DONE = 2'd2
	} walk_state_t;

	// Token carried from cell to cell during a load walk
	typedef struct packed {
		logic        stop;   // an unready/partial older store or a younger store seen
		logic        wait_f; // the load has to wait
		logic        found;  // a covering older store has been seen
		logic [63:0] fwd_addr;
		logic [63:0] fwd_data;
	} walk_tok_t;

	localparam int unsigned MAX_BYTES = 8;
	localparam int unsigned DATA_W    = 64;

endpackage

// ===== rtl/core/lsqf_cell.sv =====
// ----------------------------------------------------------------------------
// lsqf_cell: one store slot of the queue
// Holds one store and judges a passing load walk token against it.
// ----------------------------------------------------------------------------
module lsqf_cell
	import lsqf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        clr,
	input  logic        alloc,
	input  logic        set_ready,
	input  logic [31:0] seq_in,
	input  logic [63:0] addr_in,
	input  logic [3:0]  width_in,
	input  logic [63:0] data_in,
	input  logic        live,
	input  logic [31:0] ld_seq,
	input  logic [63:0] ld_addr,
	input  logic [3:0]  ld_width,
	input  walk_tok_t   tok_in,
	output walk_tok_t   tok_out
);

	logic        ready_q;
	logic [31:0] seq_q;
	logic [63:0] addr_q;
	logic [63:0] data_q;
	logic [3:0]  width_q;
	logic [64:0] diff_ls;
	logic [64:0] diff_sl;
	logic        overlap;
	logic        covers;

	// Track readiness
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q <= 1'b0;
		end else if (clr || alloc) begin
			ready_q <= 1'b0;
		end else if (set_ready) begin
			ready_q <= 1'b1;
		end
	end

	// Hold store payload
	always_ff @(posedge clk) begin
		if (alloc) begin
			seq_q <= seq_in;
		end
		if (set_ready) begin
			addr_q  <= addr_in;
			data_q  <= data_in;
			width_q <= width_in;
		end
	end

	// Compare load range against store range
	always_comb begin
		diff_ls = {1'b0, ld_addr} - {1'b0, addr_q};
		diff_sl = {1'b0, addr_q} - {1'b0, ld_addr};
		if (!diff_ls[64]) begin
			overlap = diff_ls[63:0] < {60'd0, width_q};
			covers  = (diff_ls[63:0] <= {60'd0, width_q}) &&
				({60'd0, ld_width} <= ({60'd0, width_q} - diff_ls[63:0]));
		end else begin
			overlap = diff_sl[63:0] < {60'd0, ld_width};
			covers  = 1'b0;
		end
	end

	// Advance the walk token
	always_comb begin
		tok_out = tok_in;
		if (live && !tok_in.stop) begin
			if (seq_q >= ld_seq) begin
				tok_out.stop = 1'b1;
			end else if (!ready_q) begin
				tok_out.stop   = 1'b1;
				tok_out.wait_f = 1'b1;
			end else if (overlap) begin
				if (!covers) begin
					tok_out.stop   = 1'b1;
					tok_out.wait_f = 1'b1;
				end else begin
					tok_out.found    = 1'b1;
					tok_out.fwd_addr = addr_q;
					tok_out.fwd_data = data_q;
				end
			end
		end
	end

endmodule

// ===== rtl/core/lsqf_fwd.sv =====
// ----------------------------------------------------------------------------
// lsqf_fwd: forwarded value alignment
// Shifts the store's data to the load offset, masks, and sign-extends if sx.
// ----------------------------------------------------------------------------
module lsqf_fwd
	import lsqf_pkg::*;
(
	input  logic [63:0] st_addr,
	input  logic [63:0] st_data,
	input  logic [63:0] ld_addr,
	input  logic [3:0]  ld_width,
	input  logic        sx,
	output logic [63:0] value
);

	logic [2:0]  off;
	logic [63:0] shifted;
	logic [63:0] mask;
	logic [63:0] sign;
	logic [63:0] masked;

	// Align, mask and extend
	always_comb begin
		off     = ld_addr[2:0] - st_addr[2:0];
		shifted = st_data >> {off, 3'b000};
		mask    = '1;
		sign    = '0;
		if (ld_width < 4'(MAX_BYTES)) begin
			mask = (64'd1 << {ld_width[2:0], 3'b000}) - 64'd1;
			sign = 64'd1 << ({ld_width[2:0], 3'b000} - 6'd1);
		end
		masked = shifted & mask;
		value  = masked;
		if (sx && ld_width < 4'(MAX_BYTES)) begin
			value = (masked ^ sign) - sign;
		end
	end

endmodule

// ===== rtl/core/load_store_queue_forwarding.sv =====
// ----------------------------------------------------------------------------
// load_store_queue_forwarding: load/store queue with store-to-load forwarding
// Ring of store cells; a load walks one cell per cycle from the oldest.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its result appears
// for one cycle with done high and cannot be held off. All commands except
// execute load show their result in the cycle after the request, and busy
// holds off the next request during that cycle. Execute load walks the store
// chain one cell per cycle from the head in the WALK state, then passes through
// DONE before the registered result shows; the walk ends early at the first
// younger, unready or partially overlapping store.
module load_store_queue_forwarding
	import lsqf_pkg::*;
#(
	parameter int STORE_DEPTH = 16,
	parameter int LOAD_DEPTH  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  cmd,
	input  logic [31:0] sequence_req,
	input  logic [3:0]  entry_index,
	input  logic [63:0] address,
	input  logic [3:0]  size_bytes,
	input  logic [63:0] store_data,
	input  logic        sext,
	output logic        done,
	output logic [2:0]  status,
	output logic [3:0]  allocated_index,
	output logic [63:0] load_value
);

	localparam int SW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int PW = SW + 1;
	localparam int LW = $clog2(LOAD_DEPTH + 1);

	logic [PW-1:0] head_q, tail_q;
	logic [LW-1:0] lcnt_q;
	logic [PW:0]   occ;
	logic [SW-1:0] head_slot, tail_slot;
	logic [PW-1:0] walk_ptr_q;
	logic [PW:0]   walk_cnt_q;
	walk_state_t   wstate_q, wstate_d;

	logic [31:0]   ld_seq_q;
	logic [63:0]   ld_addr_q;
	logic [3:0]    ld_width_q;
	logic          ld_sx_q;
	walk_tok_t     tok_q;
	logic [3:0]    width_c;

	logic          res_v_q;
	logic [2:0]    res_st_q;
	logic [3:0]    res_ix_q;
	logic [63:0]   res_val_q;

	logic [STORE_DEPTH-1:0] cell_alloc, cell_ready, cell_live;
	walk_tok_t     tok_in  [STORE_DEPTH];
	walk_tok_t     tok_out [STORE_DEPTH];
	logic [63:0]   fwd_val;
	logic          acc;
	cmd_t          c;
	logic          clr;
	logic          cmd_ok;
	logic [SW-1:0] idx;
	logic [PW:0]   off;

	function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
		return (32'(p) + 1 >= 2 * STORE_DEPTH) ? '0 : PW'(32'(p) + 1);
	endfunction

	function automatic logic [SW-1:0] ptr_slot(input logic [PW-1:0] p);
		return (32'(p) >= STORE_DEPTH) ? SW'(32'(p) - STORE_DEPTH) : SW'(p);
	endfunction

	assign acc       = start && !busy;
	assign c         = cmd_t'(cmd);
	assign busy      = (wstate_q != WS_IDLE) || res_v_q;
	assign head_slot = ptr_slot(head_q);
	assign tail_slot = ptr_slot(tail_q);
	assign occ = (tail_q >= head_q) ? (PW+1)'(tail_q - head_q)
		: (PW+1)'(32'(tail_q) + 2 * STORE_DEPTH - 32'(head_q));
	assign width_c = (size_bytes == 4'd0) ? 4'd1
		: (size_bytes > 4'(MAX_BYTES)) ? 4'(MAX_BYTES) : size_bytes;
	assign idx = SW'(entry_index);
	assign off = (32'(idx) >= 32'(head_slot)) ? (PW+1)'(idx - head_slot)
		: (PW+1)'(32'(idx) + STORE_DEPTH - 32'(head_slot));
	assign cmd_ok = (32'(entry_index) < STORE_DEPTH) && (off < occ);
	assign clr = acc && c == CMD_CLEAR;

	// Decode per-cell strobes
	always_comb begin
		for (int i = 0; i < STORE_DEPTH; i++) begin
			cell_alloc[i] = acc && c == CMD_ALLOC_STORE && occ < (PW+1)'(STORE_DEPTH)
				&& tail_slot == SW'(i);
			cell_ready[i] = acc && c == CMD_STORE_READY && cmd_ok && idx == SW'(i);
			cell_live[i]  = ptr_slot(walk_ptr_q) == SW'(i);
			tok_in[i]     = tok_q;
		end
	end

	// Build the cell row
	for (genvar g = 0; g < STORE_DEPTH; g++) begin : g_cell
		lsqf_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.clr      (clr),
			.alloc    (cell_alloc[g]),
			.set_ready(cell_ready[g]),
			.seq_in   (sequence_req),
			.addr_in  (address),
			.width_in (width_c),
			.data_in  (store_data),
			.live     (cell_live[g] && wstate_q == WS_WALK),
			.ld_seq   (ld_seq_q),
			.ld_addr  (ld_addr_q),
			.ld_width (ld_width_q),
			.tok_in   (tok_in[g]),
			.tok_out  (tok_out[g])
		);
	end

	lsqf_fwd u_fwd (
		.st_addr (tok_q.fwd_addr),
		.st_data (tok_q.fwd_data),
		.ld_addr (ld_addr_q),
		.ld_width(ld_width_q),
		.sx      (ld_sx_q),
		.value   (fwd_val)
	);

	// Next walk state
	always_comb begin
		wstate_d = wstate_q;
		case (wstate_q)
			WS_IDLE: if (acc && c == CMD_EXEC_LOAD) wstate_d = WS_WALK;
			WS_WALK: if (walk_cnt_q == '0 || tok_q.stop) wstate_d = WS_DONE;
			WS_DONE: wstate_d = WS_IDLE;
			default: wstate_d = WS_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			tail_q   <= '0;
			lcnt_q   <= '0;
			wstate_q <= WS_IDLE;
			res_v_q  <= 1'b0;
		end else begin
			wstate_q <= wstate_d;
			res_v_q  <= (acc && c != CMD_EXEC_LOAD) || wstate_q == WS_DONE;
			if (acc) begin
				case (c)
					CMD_ALLOC_LOAD:
						if (32'(lcnt_q) < LOAD_DEPTH) lcnt_q <= lcnt_q + 1'b1;
					CMD_ALLOC_STORE:
						if (occ < (PW+1)'(STORE_DEPTH)) tail_q <= ptr_next(tail_q);
					CMD_RETIRE_LOAD:
						if (lcnt_q != '0) lcnt_q <= lcnt_q - 1'b1;
					CMD_RETIRE_STORE:
						if (occ != '0 && entry_index == 4'(head_slot)
							&& 32'(entry_index) < STORE_DEPTH)
							head_q <= ptr_next(head_q);
					CMD_CLEAR: begin
						head_q <= '0;
						tail_q <= '0;
						lcnt_q <= '0;
					end
					default: ;
				endcase
			end
		end
	end

	// Walk datapath and result
	always_ff @(posedge clk) begin
		if (acc && c == CMD_EXEC_LOAD) begin
			ld_seq_q   <= sequence_req;
			ld_addr_q  <= address;
			ld_width_q <= width_c;
			ld_sx_q    <= sext;
			walk_ptr_q <= head_q;
			walk_cnt_q <= occ;
			tok_q      <= '0;
		end else if (wstate_q == WS_WALK && walk_cnt_q != '0 && !tok_q.stop) begin
			tok_q      <= tok_out[ptr_slot(walk_ptr_q)];
			walk_ptr_q <= ptr_next(walk_ptr_q);
			walk_cnt_q <= walk_cnt_q - 1'b1;
		end
		res_st_q  <= ST_OK;
		res_ix_q  <= '0;
		res_val_q <= '0;
		if (wstate_q == WS_DONE) begin
			if (tok_q.wait_f) begin
				res_st_q <= ST_WAIT;
			end else if (tok_q.found) begin
				res_st_q  <= ST_FWD;
				res_val_q <= fwd_val;
			end else begin
				res_st_q <= ST_MEM;
			end
		end else if (acc) begin
			case (c)
				CMD_ALLOC_LOAD:
					if (32'(lcnt_q) >= LOAD_DEPTH) res_st_q <= ST_FULL;
					else res_ix_q <= 4'(lcnt_q);
				CMD_ALLOC_STORE:
					if (occ >= (PW+1)'(STORE_DEPTH)) res_st_q <= ST_FULL;
					else res_ix_q <= 4'(tail_slot);
				CMD_STORE_READY:
					if (!cmd_ok) res_st_q <= ST_ORDER;
				CMD_RETIRE_LOAD:
					if (lcnt_q == '0) res_st_q <= ST_ORDER;
				CMD_RETIRE_STORE:
					if (occ == '0 || entry_index != 4'(head_slot)
						|| 32'(entry_index) >= STORE_DEPTH) res_st_q <= ST_ORDER;
				CMD_BAD: res_st_q <= ST_ORDER;
				default: ;
			endcase
		end
	end

	assign done            = res_v_q;
	assign status          = res_st_q;
	assign allocated_index = res_ix_q;
	assign load_value      = res_val_q;

endmodule
